@@ rtl/core/vvt_pkg.sv @@
package vvt_pkg;

	localparam int ACTOR_SLOTS = 8;
	localparam int SLOT_W      = (ACTOR_SLOTS > 1) ? $clog2(ACTOR_SLOTS) : 1;
	localparam int ACTOR_W     = 32;
	localparam int STAMP_W     = 64;

	// operation codes
	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_COVERS  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [ACTOR_W-1:0] actor_id;
		logic [STAMP_W-1:0] stamp_value;
		logic               stamp_present;
	} vvt_in_t;

	typedef struct packed {
		logic is_covered;
		logic table_overflow;
	} vvt_out_t;

endpackage

@@ rtl/core/vvt_ram.sv @@
module vvt_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/version_vector_table_core.sv @@
// channel | signals                   | payload           | accepted when
// cmd     | cmd_valid, cmd_ready, cmd | vvt_pkg::vvt_in_t  | cmd_valid && cmd_ready
// res     | res_valid, res_ready, res | vvt_pkg::vvt_out_t | res_valid && res_ready
//
// per item: the accept cycle issues the mark read, the next
// cycle compares against the registered mark and writes it back
// the mark memory has one read port and one write port, with a registered read
// a new item is taken while an earlier result still waits in the res register
// if res is still full when a result is ready, the compare cycle holds
// reset clears the valid bits and the control; actor and mark stores are not cleared
module version_vector_table_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  vvt_pkg::vvt_in_t   cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output vvt_pkg::vvt_out_t  res
);

	// state codes
	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_CMP  = 1'b1;

	logic [0:0] state_q;

	// slot bookkeeping kept in flops, one actor register per slot
	logic [vvt_pkg::ACTOR_SLOTS-1:0] valid_q;
	logic [vvt_pkg::ACTOR_W-1:0]     actor_q [vvt_pkg::ACTOR_SLOTS];

	// item held for the compare cycle
	vvt_pkg::vvt_in_t         item_q;
	logic                     hit_q;
	logic [vvt_pkg::SLOT_W-1:0] hit_idx_q;
	logic                     free_q;
	logic [vvt_pkg::SLOT_W-1:0] free_idx_q;

	// output register
	logic              res_valid_q;
	vvt_pkg::vvt_out_t res_q;

	// lookup on the incoming item
	logic                       look_hit;
	logic [vvt_pkg::SLOT_W-1:0] look_idx;
	logic                       look_free;
	logic [vvt_pkg::SLOT_W-1:0] look_free_idx;

	// mark memory
	logic                        mark_we;
	logic [vvt_pkg::SLOT_W-1:0]  mark_waddr;
	logic [vvt_pkg::SLOT_W-1:0]  mark_raddr;
	logic [vvt_pkg::STAMP_W-1:0] mark_rdata;

	logic              cmd_acc;
	logic              finish;
	logic              stamp_gt;
	logic              do_alloc;
	vvt_pkg::vvt_out_t res_d;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;

	// associative match and lowest free slot, scanned from the top so the lowest wins
	always_comb begin
		look_hit      = 1'b0;
		look_idx      = '0;
		look_free     = 1'b0;
		look_free_idx = '0;
		for (int i = vvt_pkg::ACTOR_SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && (actor_q[i] == cmd.actor_id)) begin
				look_hit = 1'b1;
				look_idx = vvt_pkg::SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				look_free     = 1'b1;
				look_free_idx = vvt_pkg::SLOT_W'(i);
			end
		end
	end

	// mark read issued in the accept cycle, data arrives for the compare cycle
	// a stalled compare cycle keeps reading the held slot so the mark stays put
	assign mark_raddr = (state_q == ST_CMP) ? hit_idx_q : look_idx;

	vvt_ram #(
		.WIDTH (vvt_pkg::STAMP_W),
		.DEPTH (vvt_pkg::ACTOR_SLOTS)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (item_q.stamp_value),
		.raddr (mark_raddr),
		.rdata (mark_rdata)
	);

	// compare cycle: decide result and write back
	assign finish   = (state_q == ST_CMP) && (!res_valid_q || res_ready);
	assign stamp_gt = item_q.stamp_value > mark_rdata;

	// new actor on observe with room left
	assign do_alloc = (item_q.operation == vvt_pkg::OP_OBSERVE) && item_q.stamp_present &&
		!hit_q && free_q;

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = hit_q ? hit_idx_q : free_idx_q;
		res_d      = '0;
		if (item_q.operation == vvt_pkg::OP_OBSERVE) begin
			if (item_q.stamp_present) begin
				if (hit_q) begin
					// raise the mark only on a strictly greater stamp
					mark_we = finish && stamp_gt;
				end else if (free_q) begin
					mark_we = finish;
				end else begin
					res_d.table_overflow = 1'b1;
				end
			end
		end else begin
			// unset stamp is always covered
			res_d.is_covered = !item_q.stamp_present || (hit_q && !stamp_gt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (finish && do_alloc) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_q     <= cmd;
			hit_q      <= look_hit;
			hit_idx_q  <= look_idx;
			free_q     <= look_free;
			free_idx_q <= look_free_idx;
		end
		if (finish) begin
			res_q <= res_d;
		end
		if (finish && do_alloc) begin
			actor_q[free_idx_q] <= item_q.actor_id;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// an accepted item always moves to the compare cycle
	a_acc_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q == ST_CMP))
		else $error("accepted item did not enter compare");

	// overflow is only reported once every slot is taken
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.table_overflow) |-> (&valid_q))
		else $error("overflow reported with a free slot");

	// covers and overflow never come together
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.is_covered && res.table_overflow))
		else $error("covered and overflow both set");

	// the mark memory is written only while finishing an item
	a_write_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		mark_we |-> finish)
		else $error("mark write outside compare");

	// a finished result lands in the output register
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> res_valid)
		else $error("finished item left no result");

endmodule

@@ tb/version_vector_table_core_test.sv @@
module version_vector_table_core_test;

	localparam int CLK_HALF     = 4;
	localparam int RANDOM_ITEMS = 800;
	localparam int TAIL_CYCLES  = 20;

	// one queued command plus a flag that makes the sender wait for an empty pipe first
	typedef struct packed {
		logic             drain_first;
		vvt_pkg::vvt_in_t item;
	} pending_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	vvt_pkg::vvt_in_t   cmd       = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	vvt_pkg::vvt_out_t  res;

	version_vector_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// predicted actor table, updated in acceptance order
	logic                        seen_valid [vvt_pkg::ACTOR_SLOTS];
	logic [vvt_pkg::ACTOR_W-1:0] seen_actor [vvt_pkg::ACTOR_SLOTS];
	logic [vvt_pkg::STAMP_W-1:0] seen_mark  [vvt_pkg::ACTOR_SLOTS];

	pending_t          cmd_backlog [$];
	vvt_pkg::vvt_out_t expected_answers [$];

	int mismatch_count = 0;
	int result_index   = 0;

	// stimulus shadow of the actor pool, only used to aim stamps near the marks
	logic [vvt_pkg::ACTOR_W-1:0] pool_actor [vvt_pkg::ACTOR_SLOTS];
	logic [vvt_pkg::STAMP_W-1:0] pool_mark  [vvt_pkg::ACTOR_SLOTS];
	logic                        pool_seen  [vvt_pkg::ACTOR_SLOTS];

	function automatic vvt_pkg::vvt_out_t predict_vector_step(input vvt_pkg::vvt_in_t c);
		vvt_pkg::vvt_out_t r;
		int hit;
		int spare;
		int i;
		r = '0;
		hit = -1;
		spare = -1;
		for (i = 0; i < vvt_pkg::ACTOR_SLOTS; i++) begin
			if (seen_valid[i] && seen_actor[i] == c.actor_id && hit < 0)
				hit = i;
			if (!seen_valid[i] && spare < 0)
				spare = i;
		end
		if (c.operation == vvt_pkg::OP_OBSERVE) begin
			if (c.stamp_present) begin
				if (hit >= 0) begin
					if (c.stamp_value > seen_mark[hit])
						seen_mark[hit] = c.stamp_value;
				end else if (spare >= 0) begin
					// new actor goes into the lowest free slot, even with a zero stamp
					seen_valid[spare] = 1'b1;
					seen_actor[spare] = c.actor_id;
					seen_mark[spare]  = c.stamp_value;
				end else begin
					r.table_overflow = 1'b1;
				end
			end
		end else begin
			// unset stamp is always covered
			if (!c.stamp_present)
				r.is_covered = 1'b1;
			else if (hit >= 0 && !(c.stamp_value > seen_mark[hit]))
				r.is_covered = 1'b1;
		end
		return r;
	endfunction

	task automatic add_item(input logic op, input logic [vvt_pkg::ACTOR_W-1:0] actor,
			input logic [vvt_pkg::STAMP_W-1:0] stamp, input logic present,
			input logic drain);
		pending_t p;
		int k;
		p.drain_first        = drain;
		p.item.operation     = op;
		p.item.actor_id      = actor;
		p.item.stamp_value   = stamp;
		p.item.stamp_present = present;
		cmd_backlog.insert(cmd_backlog.size(), p);
		if (op == vvt_pkg::OP_OBSERVE && present) begin
			for (k = 0; k < vvt_pkg::ACTOR_SLOTS; k++) begin
				if (pool_actor[k] == actor) begin
					if (!pool_seen[k] || stamp > pool_mark[k])
						pool_mark[k] = stamp;
					pool_seen[k] = 1'b1;
				end
			end
		end
	endtask

	function automatic logic [vvt_pkg::ACTOR_W-1:0] stranger_actor();
		logic [vvt_pkg::ACTOR_W-1:0] a;
		logic clash;
		int k;
		do begin
			a = $urandom;
			clash = 1'b0;
			for (k = 0; k < vvt_pkg::ACTOR_SLOTS; k++)
				if (pool_actor[k] == a)
					clash = 1'b1;
		end while (clash);
		return a;
	endfunction

	// sender: bursts of random length with random gaps between them
	int       burst_left = 1;
	int       gap_left   = 0;
	pending_t next_up;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_answers.insert(expected_answers.size(), predict_vector_step(cmd));
			// valid is only touched once the current item has gone in
			if (!cmd_valid || cmd_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].drain_first && expected_answers.size() != 0)) begin
					next_up = cmd_backlog.pop_front();
					cmd <= next_up.item;
					cmd_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between always ready, coin flip and mostly stalled
	int rx_mode        = 0;
	int mode_left      = 0;
	int hold_left      = 0;
	int rx_count       = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready)
				rx_count++;
			if (hold_left != 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!long_hold_done && rx_count >= 200) begin
				// long hold-off so the block backs up and drops cmd_ready
				long_hold_done = 1'b1;
				hold_left = 240;
				res_ready <= 1'b0;
			end else if ($urandom_range(0, 999) == 0) begin
				hold_left = $urandom_range(40, 120);
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					default: res_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// result checker against the oldest prediction
	vvt_pkg::vvt_out_t want;

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %0d: covered=%0b overflow=%0b",
						result_index, res.is_covered, res.table_overflow);
			end else begin
				want = expected_answers.pop_front();
				if (res.is_covered !== want.is_covered ||
						res.table_overflow !== want.table_overflow) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch %0d: want cov=%0b ovf=%0b, got cov=%0b ovf=%0b",
							result_index, want.is_covered, want.table_overflow,
							res.is_covered, res.table_overflow);
				end
			end
			result_index++;
		end
	end

	int                          n;
	int                          k;
	int                          pick;
	int                          tail;
	logic [vvt_pkg::STAMP_W-1:0] s;

	initial begin
		for (k = 0; k < vvt_pkg::ACTOR_SLOTS; k++) begin
			seen_valid[k] = 1'b0;
			seen_actor[k] = '0;
			seen_mark[k]  = '0;
			pool_mark[k]  = '0;
			pool_seen[k]  = 1'b0;
		end
		pool_actor[0] = '0;
		pool_actor[1] = '1;
		for (k = 2; k < vvt_pkg::ACTOR_SLOTS; k++)
			pool_actor[k] = stranger_actor();

		// directed: empty table, extremes, equal stamps, filling up, overflow
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], '0, 1'b0, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], '0, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[0], '1, 1'b0, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], '0, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[0], '0, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], '0, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], 64'd1, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[1], '1, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[1], '1, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[1], 64'd5, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[1], '0, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[0], 64'd100, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, pool_actor[0], 64'd100, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], 64'd101, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pool_actor[0], 64'd100, 1'b1, 1'b0);
		for (k = 2; k < vvt_pkg::ACTOR_SLOTS; k++)
			add_item(vvt_pkg::OP_OBSERVE, pool_actor[k], {$urandom, $urandom}, 1'b1, 1'b0);
		// table is full now
		s = {$urandom, $urandom};
		pick = stranger_actor();
		add_item(vvt_pkg::OP_OBSERVE, pick, s, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  pick, s, 1'b1, 1'b0);
		add_item(vvt_pkg::OP_OBSERVE, stranger_actor(), '1, 1'b0, 1'b0);
		add_item(vvt_pkg::OP_COVERS,  stranger_actor(), '1, 1'b0, 1'b0);

		// random: mostly pool actors with stamps around their marks
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			k = $urandom_range(0, vvt_pkg::ACTOR_SLOTS - 1);
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				if ($urandom_range(0, 3) == 0)
					s = pool_mark[k] - 64'($urandom_range(0, 3));
				else
					s = pool_mark[k] + 64'($urandom_range(0, 4));
				add_item(vvt_pkg::OP_OBSERVE, pool_actor[k], s, 1'b1,
					n == 0 || n == 250 || n == 550);
			end else if (pick < 70) begin
				if ($urandom_range(0, 1) == 0)
					s = pool_mark[k] - 64'($urandom_range(0, 3));
				else
					s = pool_mark[k] + 64'($urandom_range(0, 3));
				add_item(vvt_pkg::OP_COVERS, pool_actor[k], s, 1'b1, 1'b0);
			end else if (pick < 78) begin
				add_item(vvt_pkg::OP_OBSERVE, stranger_actor(), {$urandom, $urandom},
					1'b1, 1'b0);
			end else if (pick < 84) begin
				add_item(vvt_pkg::OP_COVERS, stranger_actor(), {$urandom, $urandom},
					1'b1, 1'b0);
			end else if (pick < 90) begin
				add_item(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
					1'b0, 1'b0);
			end else begin
				add_item(1'($urandom_range(0, 1)), pool_actor[k], {$urandom, $urandom},
					1'b1, 1'b0);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || cmd_valid || expected_answers.size() != 0)
			@(posedge clk);
		// any stray result in the tail is still caught by the checker
		for (tail = 0; tail < TAIL_CYCLES; tail++)
			@(posedge clk);

		if (mismatch_count == 0 && expected_answers.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(2 * CLK_HALF * 200000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
